[sv/cbf_pkg.sv]
// Shared types and constants of the cubic Bezier flattener.
`default_nettype none

package cbf_pkg;

    // Coordinate and point-set types.
    typedef logic signed [15:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t ctrl1_x;
        coord_t ctrl1_y;
        coord_t ctrl2_x;
        coord_t ctrl2_y;
        coord_t end_x;
        coord_t end_y;
    } pts_t;

    // One result word as it leaves the block.
    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   draw_segment;
        logic   last_point;
    } res_t;

    // Control tag that travels down the evaluation pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tag_t;

    // Sample index and point count limits.
    localparam int IDX_W     = 6;
    localparam int MAX_COUNT = 64;
    localparam int MIN_COUNT = 2;

    // Q1.16 unit value of the curve parameter.
    localparam int          T_W     = 17;
    localparam logic [16:0] Q16_ONE = 17'h10000;

    // Weights are Q1.48; split point for the partial products.
    localparam int W_W      = 49;
    localparam int W_LO_W   = 32;
    localparam int ACC_W    = 68;
    localparam int SHIFT_W  = 48;

    // Result queue depth and its pointer and count widths.
    localparam int OUT_DEPTH = 16;
    localparam int OUT_PTR_W = 4;
    localparam int OUT_CNT_W = 5;

endpackage

`default_nettype wire

[sv/cbf_front.sv]
// Front end: two-entry queue of accepted control point sets.
`default_nettype none

module cbf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire cbf_pkg::pts_t in_pts,
    output logic               head_valid,
    output cbf_pkg::pts_t      head,
    input  wire logic          head_pop
);

    cbf_pkg::pts_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    // Handshake decode.
    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= in_pts;
        end
    end

endmodule

`default_nettype wire

[sv/cbf_back.sv]
// Back end: sample sequencer and pipelined Bernstein evaluation.
`default_nettype none

module cbf_back #(
    parameter int SAMPLE_COUNT = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire cbf_pkg::pts_t head,
    output logic               head_pop,
    input  wire logic          out_pop,
    output logic               wr_en,
    output cbf_pkg::res_t      wr_data
);

    // Effective point count after clamping to the supported range.
    localparam int N_PTS = (SAMPLE_COUNT < cbf_pkg::MIN_COUNT) ? cbf_pkg::MIN_COUNT :
                           (SAMPLE_COUNT > cbf_pkg::MAX_COUNT) ? cbf_pkg::MAX_COUNT :
                           SAMPLE_COUNT;
    localparam logic [cbf_pkg::IDX_W-1:0] LAST_IDX = cbf_pkg::IDX_W'(N_PTS - 1);
    localparam int NSTG = 7;

    // Constant table of t = floor(i * 2^16 / (count - 1)).
    logic [cbf_pkg::T_W-1:0] t_tab [cbf_pkg::MAX_COUNT];

    for (genvar g = 0; g < cbf_pkg::MAX_COUNT; g++)
    begin : g_ttab
        if (g < N_PTS)
        begin : g_used
            localparam int unsigned TV = (g * 65536) / (N_PTS - 1);
            assign t_tab[g] = cbf_pkg::T_W'(TV);
        end
        else
        begin : g_unused
            assign t_tab[g] = '0;
        end
    end

    // Sequencer and credit state.
    logic [cbf_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [cbf_pkg::OUT_CNT_W-1:0] credit_reg, credit_next;
    logic                          issue;
    logic                          idx_last;

    // Pipeline tags, one per stage.
    cbf_pkg::tag_t tag_reg [NSTG];
    cbf_pkg::tag_t tag_next0;

    // Stage payload registers.
    logic [cbf_pkg::IDX_W-1:0] st0_idx_reg;
    cbf_pkg::pts_t             pts_reg [4];
    logic [cbf_pkg::T_W-1:0]   st1_t_reg, st1_u_reg;
    // t and u one stage later, alongside the second-order products.
    logic [cbf_pkg::T_W-1:0]   st1_t_carry, st1_u_carry;
    logic [33:0]               st2_tt_reg, st2_uu_reg, st2_tu_reg;
    logic [cbf_pkg::W_W-1:0]   st3_w_reg [4];
    logic signed [48:0]        st4_lo_x_reg [4], st4_lo_y_reg [4];
    logic signed [33:0]        st4_hi_x_reg [4], st4_hi_y_reg [4];
    logic signed [50:0]        st5_lo_x_reg, st5_lo_y_reg;
    logic signed [35:0]        st5_hi_x_reg, st5_hi_y_reg;
    logic signed [cbf_pkg::ACC_W-1:0] st6_acc_x_reg, st6_acc_y_reg;

    // Combinational stage values.
    logic [cbf_pkg::T_W-1:0]   st1_t_next, st1_u_next;
    logic [33:0]               st2_tt_next, st2_uu_next, st2_tu_next;
    logic [50:0]               m_tuu, m_ttu;
    logic [50:0]               m_uuu, m_ttt;
    logic [cbf_pkg::W_W-1:0]   st3_w_next [4];
    cbf_pkg::coord_t           px [4], py [4];
    logic signed [32:0]        w_lo_s [4];
    logic signed [17:0]        w_hi_s [4];
    logic signed [48:0]        st4_lo_x_next [4], st4_lo_y_next [4];
    logic signed [33:0]        st4_hi_x_next [4], st4_hi_y_next [4];
    logic signed [50:0]        st5_lo_x_next, st5_lo_y_next;
    logic signed [35:0]        st5_hi_x_next, st5_hi_y_next;
    logic signed [cbf_pkg::ACC_W-1:0] st6_acc_x_next, st6_acc_y_next;
    cbf_pkg::coord_t           res_x, res_y;

    // Issue one sample when a point set waits and a result queue slot is free to reserve.
    assign idx_last = (idx_reg == LAST_IDX);
    assign issue    = head_valid && (credit_reg < cbf_pkg::OUT_CNT_W'(cbf_pkg::OUT_DEPTH));
    assign head_pop = issue && idx_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = idx_last ? '0 : idx_reg + 1'b1;
        end
        credit_next = credit_reg;
        if (issue && !out_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (out_pop && !issue)
        begin
            credit_next = credit_reg - 1'b1;
        end
        tag_next0.valid = issue;
        tag_next0.first = (idx_reg == '0);
        tag_next0.last  = idx_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            credit_reg <= '0;
            for (int s = 0; s < NSTG; s++)
            begin
                tag_reg[s] <= '0;
            end
        end
        else
        begin
            idx_reg    <= idx_next;
            credit_reg <= credit_next;
            tag_reg[0] <= tag_next0;
            for (int s = 1; s < NSTG; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    // Stage 1: look up t and form u = 1 - t.
    assign st1_t_next = t_tab[st0_idx_reg];
    assign st1_u_next = cbf_pkg::Q16_ONE - st1_t_next;

    // Stage 2: second-order products of t and u.
    assign st2_tt_next = 34'(st1_t_reg) * 34'(st1_t_reg);
    assign st2_uu_next = 34'(st1_u_reg) * 34'(st1_u_reg);
    assign st2_tu_next = 34'(st1_t_reg) * 34'(st1_u_reg);

    // Stage 3: the four Bernstein weights in Q1.48.
    always_comb
    begin
        m_uuu = 51'(st2_uu_reg) * 51'(st1_u_carry);
        m_tuu = 51'(st2_tu_reg) * 51'(st1_u_carry);
        m_ttu = 51'(st2_tu_reg) * 51'(st1_t_carry);
        m_ttt = 51'(st2_tt_reg) * 51'(st1_t_carry);
        st3_w_next[0] = cbf_pkg::W_W'(m_uuu);
        st3_w_next[1] = cbf_pkg::W_W'(m_tuu + (m_tuu << 1));
        st3_w_next[2] = cbf_pkg::W_W'(m_ttu + (m_ttu << 1));
        st3_w_next[3] = cbf_pkg::W_W'(m_ttt);
    end

    // Stage 4: partial products of each weight with each coordinate.
    always_comb
    begin
        px[0] = pts_reg[3].start_x;
        px[1] = pts_reg[3].ctrl1_x;
        px[2] = pts_reg[3].ctrl2_x;
        px[3] = pts_reg[3].end_x;
        py[0] = pts_reg[3].start_y;
        py[1] = pts_reg[3].ctrl1_y;
        py[2] = pts_reg[3].ctrl2_y;
        py[3] = pts_reg[3].end_y;
        for (int k = 0; k < 4; k++)
        begin
            w_lo_s[k] = $signed({1'b0, st3_w_reg[k][cbf_pkg::W_LO_W-1:0]});
            w_hi_s[k] = $signed({1'b0, st3_w_reg[k][cbf_pkg::W_W-1:cbf_pkg::W_LO_W]});
            st4_lo_x_next[k] = 49'(w_lo_s[k]) * 49'(px[k]);
            st4_lo_y_next[k] = 49'(w_lo_s[k]) * 49'(py[k]);
            st4_hi_x_next[k] = 34'(w_hi_s[k]) * 34'(px[k]);
            st4_hi_y_next[k] = 34'(w_hi_s[k]) * 34'(py[k]);
        end
    end

    // Stage 5: sum the low and high partial products separately.
    always_comb
    begin
        st5_lo_x_next = 51'(st4_lo_x_reg[0]) + 51'(st4_lo_x_reg[1])
                      + 51'(st4_lo_x_reg[2]) + 51'(st4_lo_x_reg[3]);
        st5_lo_y_next = 51'(st4_lo_y_reg[0]) + 51'(st4_lo_y_reg[1])
                      + 51'(st4_lo_y_reg[2]) + 51'(st4_lo_y_reg[3]);
        st5_hi_x_next = 36'(st4_hi_x_reg[0]) + 36'(st4_hi_x_reg[1])
                      + 36'(st4_hi_x_reg[2]) + 36'(st4_hi_x_reg[3]);
        st5_hi_y_next = 36'(st4_hi_y_reg[0]) + 36'(st4_hi_y_reg[1])
                      + 36'(st4_hi_y_reg[2]) + 36'(st4_hi_y_reg[3]);
    end

    // Stage 6: join the two halves into the exact weighted sum.
    assign st6_acc_x_next = (cbf_pkg::ACC_W'(st5_hi_x_reg) <<< cbf_pkg::W_LO_W)
                          + cbf_pkg::ACC_W'(st5_lo_x_reg);
    assign st6_acc_y_next = (cbf_pkg::ACC_W'(st5_hi_y_reg) <<< cbf_pkg::W_LO_W)
                          + cbf_pkg::ACC_W'(st5_lo_y_reg);

    // Divide by 2^48 toward zero, then clamp to the coordinate range.
    function automatic cbf_pkg::coord_t round_sat(input logic signed [67:0] acc);
        logic signed [67:0] adj;
        logic signed [19:0] q;
        adj = acc;
        if (acc[67])
        begin
            adj = acc + 68'(48'hFFFF_FFFF_FFFF);
        end
        q = adj[67:48];
        if (q > 20'sd32767)
        begin
            round_sat = 16'sh7FFF;
        end
        else if (q < -20'sd32768)
        begin
            round_sat = 16'sh8000;
        end
        else
        begin
            round_sat = q[15:0];
        end
    endfunction

    assign res_x = round_sat(st6_acc_x_reg);
    assign res_y = round_sat(st6_acc_y_reg);

    // Final stage writes the result queue directly.
    assign wr_en                = tag_reg[NSTG-1].valid;
    assign wr_data.point_x      = res_x;
    assign wr_data.point_y      = res_y;
    assign wr_data.draw_segment = !tag_reg[NSTG-1].first;
    assign wr_data.last_point   = tag_reg[NSTG-1].last;

    // Pipeline payload registers; the tags qualify them.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            st0_idx_reg <= idx_reg;
            pts_reg[0]  <= head;
        end
        pts_reg[1]    <= pts_reg[0];
        pts_reg[2]    <= pts_reg[1];
        pts_reg[3]    <= pts_reg[2];
        st1_t_reg     <= st1_t_next;
        st1_u_reg     <= st1_u_next;
        st1_t_carry   <= st1_t_reg;
        st1_u_carry   <= st1_u_reg;
        st2_tt_reg    <= st2_tt_next;
        st2_uu_reg    <= st2_uu_next;
        st2_tu_reg    <= st2_tu_next;
        for (int k = 0; k < 4; k++)
        begin
            st3_w_reg[k]    <= st3_w_next[k];
            st4_lo_x_reg[k] <= st4_lo_x_next[k];
            st4_lo_y_reg[k] <= st4_lo_y_next[k];
            st4_hi_x_reg[k] <= st4_hi_x_next[k];
            st4_hi_y_reg[k] <= st4_hi_y_next[k];
        end
        st5_lo_x_reg  <= st5_lo_x_next;
        st5_lo_y_reg  <= st5_lo_y_next;
        st5_hi_x_reg  <= st5_hi_x_next;
        st5_hi_y_reg  <= st5_hi_y_next;
        st6_acc_x_reg <= st6_acc_x_next;
        st6_acc_y_reg <= st6_acc_y_next;
    end

endmodule

`default_nettype wire

[sv/cbf_rfifo.sv]
// Result queue between the evaluation pipeline and the output ports.
`default_nettype none

module cbf_rfifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire cbf_pkg::res_t wr_data,
    input  wire logic          rd_en,
    output logic               empty,
    output cbf_pkg::res_t      rd_data
);

    cbf_pkg::res_t                 entry_reg [cbf_pkg::OUT_DEPTH];
    logic [cbf_pkg::OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cbf_pkg::OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cbf_pkg::OUT_CNT_W-1:0] count_reg, count_next;
    logic                          do_rd;

    // The oldest word is always presented while the queue holds one.
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_rd   = rd_en && !empty;

    // Pointers wrap naturally; the sequencer's credits prevent overflow.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[sv/cubic_bezier_flattener.sv]
// The first point of a curve passes the input queue, the pipeline stages and the result queue
// on its way to the ports. The single-issue sample sequencer feeds the evaluation pipeline
// one point per cycle while a curve waits and the result queue has a free slot.
// A two-word input queue lets the next curve wait while the current one is sampled.
// Reset clears all queues, the sample counter and the pipeline valid bits at once.
// Top level of the cubic Bezier flattener.
`default_nettype none

module cubic_bezier_flattener #(
    parameter int SAMPLE_COUNT = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic signed [15:0]     start_x,
    input  wire logic signed [15:0]     start_y,
    input  wire logic signed [15:0]     ctrl1_x,
    input  wire logic signed [15:0]     ctrl1_y,
    input  wire logic signed [15:0]     ctrl2_x,
    input  wire logic signed [15:0]     ctrl2_y,
    input  wire logic signed [15:0]     end_x,
    input  wire logic signed [15:0]     end_y,
    output logic                        empty,
    input  wire logic                   pop,
    output logic signed [15:0]          point_x,
    output logic signed [15:0]          point_y,
    output logic                        draw_segment,
    output logic                        last_point
);

    cbf_pkg::pts_t in_pts;
    cbf_pkg::pts_t head;
    cbf_pkg::res_t wr_data;
    cbf_pkg::res_t rd_data;
    logic          head_valid;
    logic          head_pop;
    logic          wr_en;
    logic          out_pop;

    // Gather the incoming word.
    assign in_pts.start_x = start_x;
    assign in_pts.start_y = start_y;
    assign in_pts.ctrl1_x = ctrl1_x;
    assign in_pts.ctrl1_y = ctrl1_y;
    assign in_pts.ctrl2_x = ctrl2_x;
    assign in_pts.ctrl2_y = ctrl2_y;
    assign in_pts.end_x   = end_x;
    assign in_pts.end_y   = end_y;

    // A result word leaves when it is popped from a non-empty queue.
    assign out_pop = pop && !empty;

    cbf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_pts     (in_pts),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    cbf_back #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .out_pop    (out_pop),
        .wr_en      (wr_en),
        .wr_data    (wr_data)
    );

    cbf_rfifo u_rfifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (pop),
        .empty   (empty),
        .rd_data (rd_data)
    );

    // Split the result word onto the ports.
    assign point_x      = rd_data.point_x;
    assign point_y      = rd_data.point_y;
    assign draw_segment = rd_data.draw_segment;
    assign last_point   = rd_data.last_point;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the cubic Bezier flattener: directed and random curves, bit-exact checking.
module tb_top;

    localparam int SAMPLE_COUNT = 16;
    localparam int CURVE_POINTS =
        (SAMPLE_COUNT < cbf_pkg::MIN_COUNT) ? cbf_pkg::MIN_COUNT :
        (SAMPLE_COUNT > cbf_pkg::MAX_COUNT) ? cbf_pkg::MAX_COUNT : SAMPLE_COUNT;
    localparam int DRAIN_CYCLES = 40;
    localparam logic signed [79:0] WEIGHT_ONE = 80'sd1 <<< cbf_pkg::SHIFT_W;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            push = 1'b0;
    logic            pop = 1'b0;
    logic            full;
    logic            empty;
    cbf_pkg::coord_t start_x = '0;
    cbf_pkg::coord_t start_y = '0;
    cbf_pkg::coord_t ctrl1_x = '0;
    cbf_pkg::coord_t ctrl1_y = '0;
    cbf_pkg::coord_t ctrl2_x = '0;
    cbf_pkg::coord_t ctrl2_y = '0;
    cbf_pkg::coord_t end_x = '0;
    cbf_pkg::coord_t end_y = '0;
    cbf_pkg::coord_t point_x;
    cbf_pkg::coord_t point_y;
    logic            draw_segment;
    logic            last_point;

    // Points still owed by the block, oldest first.
    cbf_pkg::res_t   pending_points[$];
    int              error_count = 0;
    int              send_gap_pct = 0;
    int              pop_stall_pct = 0;

    cubic_bezier_flattener #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .start_x      (start_x),
        .start_y      (start_y),
        .ctrl1_x      (ctrl1_x),
        .ctrl1_y      (ctrl1_y),
        .ctrl2_x      (ctrl2_x),
        .ctrl2_y      (ctrl2_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .empty        (empty),
        .pop          (pop),
        .point_x      (point_x),
        .point_y      (point_y),
        .draw_segment (draw_segment),
        .last_point   (last_point)
    );

    always #4 clk = ~clk;

    // One axis of the Bernstein form at sample idx, with exact Q1.48 weights.
    function automatic cbf_pkg::coord_t bernstein_axis(
        input cbf_pkg::coord_t p0, input cbf_pkg::coord_t p1,
        input cbf_pkg::coord_t p2, input cbf_pkg::coord_t p3,
        input int unsigned idx);
        logic [79:0]        t_q16;
        logic [79:0]        u_q16;
        logic signed [79:0] w0;
        logic signed [79:0] w1;
        logic signed [79:0] w2;
        logic signed [79:0] w3;
        logic signed [79:0] acc;
        logic signed [79:0] quot;
        t_q16 = (80'(idx) << 16) / 80'(CURVE_POINTS - 1);
        u_q16 = 80'(cbf_pkg::Q16_ONE) - t_q16;
        w0 = u_q16 * u_q16 * u_q16;
        w1 = 80'd3 * t_q16 * u_q16 * u_q16;
        w2 = 80'd3 * t_q16 * t_q16 * u_q16;
        w3 = t_q16 * t_q16 * t_q16;
        acc = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
        // Signed division truncates toward zero.
        quot = acc / WEIGHT_ONE;
        if (quot > 32767)
        begin
            return 16'sh7fff;
        end
        if (quot < -32768)
        begin
            return 16'sh8000;
        end
        return quot[15:0];
    endfunction

    // Queue up the whole polyline that one accepted curve must produce.
    function automatic void sample_curve(input cbf_pkg::pts_t c);
        cbf_pkg::res_t pt;
        for (int unsigned i = 0; i < CURVE_POINTS; i++)
        begin
            pt.point_x      = bernstein_axis(c.start_x, c.ctrl1_x, c.ctrl2_x, c.end_x, i);
            pt.point_y      = bernstein_axis(c.start_y, c.ctrl1_y, c.ctrl2_y, c.end_y, i);
            pt.draw_segment = (i != 0);
            pt.last_point   = (i == CURVE_POINTS - 1);
            pending_points.push_back(pt);
        end
    endfunction

    // Random coordinate: full range, a narrow band around zero, or an extreme.
    function automatic cbf_pkg::coord_t rand_coord(input int unsigned style);
        case (style)
            0: return cbf_pkg::coord_t'($urandom);
            1: return cbf_pkg::coord_t'($signed(17'($urandom_range(128)) - 17'sd64));
            default:
            begin
                case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
        endcase
    endfunction

    // Offer one curve word, with a random gap first, and record its points on acceptance.
    task automatic send_curve(input cbf_pkg::pts_t c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        start_x <= c.start_x;
        start_y <= c.start_y;
        ctrl1_x <= c.ctrl1_x;
        ctrl1_y <= c.ctrl1_y;
        ctrl2_x <= c.ctrl2_x;
        ctrl2_y <= c.ctrl2_y;
        end_x   <= c.end_x;
        end_y   <= c.end_y;
        push    <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (full);
        sample_curve(c);
    endtask

    // Hold the input low until every owed point has been popped.
    task automatic wait_for_drain();
        push <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Extremes of every field, hull corners, bit patterns, degenerate curves and random words.
    task automatic test_corner_curves();
        cbf_pkg::pts_t c;
        send_curve('{default: 16'sh0000});
        send_curve('{default: 16'sh7fff});
        send_curve('{default: 16'sh8000});
        send_curve('{default: 16'shffff});
        send_curve('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                     16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
        send_curve('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                     16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
        send_curve('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                     16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
        send_curve('{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
                     16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555});
        // A straight line with the control points on it.
        send_curve('{16'sh0000, 16'sh0000, 16'sd333, -16'sd333,
                     16'sd666, -16'sd666, 16'sd1000, -16'sd1000});
        // All four points the same: every sample sits on that point.
        send_curve('{default: -16'sd1234});
        // Small negative values exercise truncation toward zero.
        send_curve('{-16'sd1, -16'sd1, 16'sd0, 16'sd0,
                     16'sd0, 16'sd0, -16'sd2, 16'sd1});
        for (int k = 0; k < 4; k++)
        begin
            c = cbf_pkg::pts_t'({$urandom, $urandom, $urandom, $urandom});
            send_curve(c);
        end
    endtask

    // Fully random curves, or curves with a style picked per field, so ranges and extremes mix freely.
    task automatic test_random_curves(input int count);
        cbf_pkg::pts_t c;
        int unsigned   style;
        for (int k = 0; k < count; k++)
        begin
            style = $urandom_range(9);
            if (style < 6)
            begin
                c = cbf_pkg::pts_t'({$urandom, $urandom, $urandom, $urandom});
            end
            else
            begin
                c.start_x = rand_coord($urandom_range(2));
                c.start_y = rand_coord($urandom_range(2));
                c.ctrl1_x = rand_coord($urandom_range(2));
                c.ctrl1_y = rand_coord($urandom_range(2));
                c.ctrl2_x = rand_coord($urandom_range(2));
                c.ctrl2_y = rand_coord($urandom_range(2));
                c.end_x   = rand_coord($urandom_range(2));
                c.end_y   = rand_coord($urandom_range(2));
            end
            send_curve(c);
        end
    endtask

    // Let the block run dry, then restart it with ten random curves.
    task automatic test_drain_then_burst();
        wait_for_drain();
        test_random_curves(10);
    endtask

    // Pop at random and compare each popped word with the oldest owed point.
    always @(posedge clk)
    begin
        cbf_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_points.size() == 0)
            begin
                $error("unexpected word: x %0d y %0d draw %0b last %0b",
                       point_x, point_y, draw_segment, last_point);
                error_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_x !== want.point_x)
                begin
                    $error("point_x: expected %0d, got %0d", want.point_x, point_x);
                    error_count++;
                end
                if (point_y !== want.point_y)
                begin
                    $error("point_y: expected %0d, got %0d", want.point_y, point_y);
                    error_count++;
                end
                if (draw_segment !== want.draw_segment)
                begin
                    $error("draw_segment: expected %0b, got %0b",
                           want.draw_segment, draw_segment);
                    error_count++;
                end
                if (last_point !== want.last_point)
                begin
                    $error("last_point: expected %0b, got %0b", want.last_point, last_point);
                    error_count++;
                end
            end
        end
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Main sequence: reset, then the tests under each idling pattern.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct  = 35;
        pop_stall_pct = 77;
        test_corner_curves();
        test_random_curves(90);

        send_gap_pct  = 77;
        pop_stall_pct = 35;
        test_random_curves(90);
        test_drain_then_burst();

        send_gap_pct  = 0;
        pop_stall_pct = 0;
        test_random_curves(90);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_points.size() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Hard stop if the block hangs.
    initial
    begin
        #(8 * 400_000);
        $display("tb_top: errors");
        $finish;
    end

endmodule

[sim.f]
sv/cbf_pkg.sv
sv/cbf_front.sv
sv/cbf_back.sv
sv/cbf_rfifo.sv
sv/cubic_bezier_flattener.sv
tb/sv/tb_top.sv
